/* design/mck_pkg.sv */
// Shared constants, types and the Morse code table for the character keyer.
package mck_pkg;

    localparam int MAX_SYMBOLS = 5;           // default symbol limit per character
    localparam int CODE_SYMS   = 5;           // longest code in the table
    localparam int QUEUE_DEPTH = 2;           // descriptors between front and back

    localparam int CHAR_W  = 7;
    localparam int DUR_W   = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 7'h20;
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 7'h0A;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DOT_TIME    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DASH_TIME   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_GAP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LETTER_GAP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WORD_GAP    = 3'd4;

    localparam logic [DUR_W-1:0] RST_DOT_TIME    = 16'd60;
    localparam logic [DUR_W-1:0] RST_DASH_TIME   = 16'd180;
    localparam logic [DUR_W-1:0] RST_ELEMENT_GAP = 16'd60;
    localparam logic [DUR_W-1:0] RST_LETTER_GAP  = 16'd180;
    localparam logic [DUR_W-1:0] RST_WORD_GAP    = 16'd420;

    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] idx;
        logic [DUR_W-1:0]     data;
    } t_cfg_wr;

    // pat bit i is symbol i, 1 = dash
    typedef struct packed {
        logic [2:0]           len;
        logic [CODE_SYMS-1:0] pat;
    } t_code;

    function automatic t_code mck_lookup(input logic [CHAR_W-1:0] ch);
        t_code c;
        c = '0;
        case (ch)
            7'h41: c = '{len: 3'd2, pat: 5'b00010};  // A
            7'h42: c = '{len: 3'd4, pat: 5'b00001};  // B
            7'h43: c = '{len: 3'd4, pat: 5'b00101};  // C
            7'h44: c = '{len: 3'd3, pat: 5'b00001};  // D
            7'h45: c = '{len: 3'd1, pat: 5'b00000};  // E
            7'h46: c = '{len: 3'd4, pat: 5'b00100};  // F
            7'h47: c = '{len: 3'd3, pat: 5'b00011};  // G
            7'h48: c = '{len: 3'd4, pat: 5'b00000};  // H
            7'h49: c = '{len: 3'd2, pat: 5'b00000};  // I
            7'h4A: c = '{len: 3'd4, pat: 5'b01110};  // J
            7'h4B: c = '{len: 3'd3, pat: 5'b00101};  // K
            7'h4C: c = '{len: 3'd4, pat: 5'b00010};  // L
            7'h4D: c = '{len: 3'd2, pat: 5'b00011};  // M
            7'h4E: c = '{len: 3'd2, pat: 5'b00001};  // N
            7'h4F: c = '{len: 3'd3, pat: 5'b00111};  // O
            7'h50: c = '{len: 3'd4, pat: 5'b00110};  // P
            7'h51: c = '{len: 3'd4, pat: 5'b01011};  // Q
            7'h52: c = '{len: 3'd3, pat: 5'b00010};  // R
            7'h53: c = '{len: 3'd3, pat: 5'b00000};  // S
            7'h54: c = '{len: 3'd1, pat: 5'b00001};  // T
            7'h55: c = '{len: 3'd3, pat: 5'b00100};  // U
            7'h56: c = '{len: 3'd4, pat: 5'b01000};  // V
            7'h57: c = '{len: 3'd3, pat: 5'b00110};  // W
            7'h58: c = '{len: 3'd4, pat: 5'b01001};  // X
            7'h59: c = '{len: 3'd4, pat: 5'b01101};  // Y
            7'h5A: c = '{len: 3'd4, pat: 5'b00011};  // Z
            7'h31: c = '{len: 3'd5, pat: 5'b11110};  // 1
            7'h32: c = '{len: 3'd5, pat: 5'b11100};  // 2
            7'h33: c = '{len: 3'd5, pat: 5'b11000};  // 3
            7'h34: c = '{len: 3'd5, pat: 5'b10000};  // 4
            7'h35: c = '{len: 3'd5, pat: 5'b00000};  // 5
            7'h36: c = '{len: 3'd5, pat: 5'b00001};  // 6
            7'h37: c = '{len: 3'd5, pat: 5'b00011};  // 7
            7'h38: c = '{len: 3'd5, pat: 5'b00111};  // 8
            7'h39: c = '{len: 3'd5, pat: 5'b01111};  // 9
            7'h30: c = '{len: 3'd5, pat: 5'b11111};  // 0
            CHAR_NEWLINE: c = '{len: 3'd5, pat: 5'b01010};  // AR prosign
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

/* design/mck_front.sv */
// Front end: accepts characters and turns each into a code descriptor.
module mck_front #(
    parameter int MAX_SYMBOLS = mck_pkg::MAX_SYMBOLS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [mck_pkg::CHAR_W-1:0]  i_char,
    output logic                        o_push,
    input  logic                        i_q_ready,
    output logic [1+$clog2(MAX_SYMBOLS+1)+MAX_SYMBOLS-1:0] o_desc
);
    localparam int LEN_W  = $clog2(MAX_SYMBOLS + 1);
    localparam int DESC_W = 1 + LEN_W + MAX_SYMBOLS;

    logic                    r_valid;
    logic [DESC_W-1:0]       r_desc;
    logic [DESC_W-1:0]       n_desc;
    mck_pkg::t_code          code;
    logic [LEN_W-1:0]        len_ext;
    logic [LEN_W-1:0]        len_cut;
    logic [MAX_SYMBOLS-1:0]  pat_ext;
    logic                    is_space;
    logic                    take;

    assign o_ready = !r_valid || i_q_ready;
    assign take    = i_valid && o_ready;
    assign o_push  = r_valid;
    assign o_desc  = r_desc;

    always_comb begin
        code     = mck_pkg::mck_lookup(i_char);
        is_space = (i_char == mck_pkg::CHAR_SPACE);
        len_ext  = LEN_W'(code.len);
        len_cut  = (len_ext > LEN_W'(MAX_SYMBOLS)) ? LEN_W'(MAX_SYMBOLS) : len_ext;
        pat_ext  = (MAX_SYMBOLS)'(code.pat);
        // desc layout, low to high: is_space, len, pat
        n_desc   = {pat_ext, len_cut, is_space};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_q_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_desc <= n_desc;
        end
    end

endmodule

/* design/mck_queue.sv */
// Short descriptor queue between the front end and the element sequencer.
module mck_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data
);
    localparam int DEPTH = mck_pkg::QUEUE_DEPTH;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);

    logic [WIDTH-1:0] r_slot [DEPTH];
    logic [WIDTH-1:0] n_slot [DEPTH];
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [IDX_W-1:0] wr_idx;
    logic             push;
    logic             pop;

    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_slot[0];
    assign push    = i_push && o_ready;
    assign pop     = i_pop && o_valid;
    assign wr_idx  = IDX_W'(r_count - CNT_W'(pop));

    // slot 0 is always the head; a pop shifts everything down by one
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            n_slot[i] = r_slot[i];
        end
        if (pop) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                n_slot[i] = r_slot[i + 1];
            end
        end
        if (push) begin
            n_slot[wr_idx] = i_data;
        end
        n_count = r_count + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DEPTH; i++) begin
            r_slot[i] <= n_slot[i];
        end
    end

endmodule

/* design/mck_back.sv */
// Back end: timing registers and the sequencer that emits keying elements.
module mck_back #(
    parameter int MAX_SYMBOLS = mck_pkg::MAX_SYMBOLS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mck_pkg::t_cfg_wr            i_cfg,
    input  logic                        i_q_valid,
    output logic                        o_q_pop,
    input  logic [1+$clog2(MAX_SYMBOLS+1)+MAX_SYMBOLS-1:0] i_q_desc,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_tone,
    output logic [mck_pkg::DUR_W-1:0]   o_dur,
    output logic                        o_last
);
    localparam int LEN_W  = $clog2(MAX_SYMBOLS + 1);
    localparam int SYM_W  = $clog2(MAX_SYMBOLS);
    localparam int DESC_W = 1 + LEN_W + MAX_SYMBOLS;
    localparam int DUR_W  = mck_pkg::DUR_W;

    typedef enum logic [2:0] {
        ST_LEAD = 3'b001,   // word gap or letter gap
        ST_SYM  = 3'b010,   // dot or dash tone
        ST_GAP  = 3'b100    // element gap between symbols
    } t_state;

    t_state                 r_state;
    t_state                 n_state;
    logic [SYM_W-1:0]       r_sym;
    logic [SYM_W-1:0]       n_sym;

    logic [DUR_W-1:0]       r_dot;
    logic [DUR_W-1:0]       r_dash;
    logic [DUR_W-1:0]       r_egap;
    logic [DUR_W-1:0]       r_lgap;
    logic [DUR_W-1:0]       r_wgap;

    logic                   r_ovalid;
    logic                   r_otone;
    logic [DUR_W-1:0]       r_odur;
    logic                   r_olast;

    logic                   d_space;
    logic [LEN_W-1:0]       d_len;
    logic [MAX_SYMBOLS-1:0] d_pat;
    logic                   el_tone;
    logic [DUR_W-1:0]       el_dur;
    logic                   el_last;
    logic                   ld;
    logic                   go;

    assign d_space = i_q_desc[0];
    assign d_len   = i_q_desc[LEN_W:1];
    assign d_pat   = i_q_desc[DESC_W-1:LEN_W+1];

    assign ld      = !r_ovalid || i_ready;
    assign go      = ld && i_q_valid;
    assign o_q_pop = go && el_last;

    assign o_valid = r_ovalid;
    assign o_tone  = r_otone;
    assign o_dur   = r_odur;
    assign o_last  = r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot  <= mck_pkg::RST_DOT_TIME;
            r_dash <= mck_pkg::RST_DASH_TIME;
            r_egap <= mck_pkg::RST_ELEMENT_GAP;
            r_lgap <= mck_pkg::RST_LETTER_GAP;
            r_wgap <= mck_pkg::RST_WORD_GAP;
        end else if (i_cfg.we) begin
            unique case (i_cfg.idx)
                mck_pkg::CFG_DOT_TIME:    r_dot  <= i_cfg.data;
                mck_pkg::CFG_DASH_TIME:   r_dash <= i_cfg.data;
                mck_pkg::CFG_ELEMENT_GAP: r_egap <= i_cfg.data;
                mck_pkg::CFG_LETTER_GAP:  r_lgap <= i_cfg.data;
                mck_pkg::CFG_WORD_GAP:    r_wgap <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // element for the descriptor at the queue head, chosen by state
    always_comb begin
        el_tone = 1'b0;
        el_dur  = r_egap;
        el_last = 1'b0;
        n_state = r_state;
        n_sym   = r_sym;
        unique case (r_state)
            ST_LEAD: begin
                el_dur  = d_space ? r_wgap : r_lgap;
                el_last = d_space || (d_len == '0);
                n_state = el_last ? ST_LEAD : ST_SYM;
                n_sym   = '0;
            end
            ST_SYM: begin
                el_tone = 1'b1;
                el_dur  = d_pat[r_sym] ? r_dash : r_dot;
                el_last = ((LEN_W'(r_sym) + LEN_W'(1)) == d_len);
                n_state = el_last ? ST_LEAD : ST_GAP;
            end
            ST_GAP: begin
                n_state = ST_SYM;
                n_sym   = r_sym + SYM_W'(1);
            end
            default: begin
                n_state = ST_LEAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_LEAD;
            r_sym    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (go) begin
                r_state <= n_state;
                r_sym   <= n_sym;
            end
            if (ld) begin
                r_ovalid <= i_q_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_otone <= el_tone;
            r_odur  <= el_dur;
            r_olast <= el_last;
        end
    end

`ifndef SYNTHESIS
    a_last_returns_lead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        go && el_last |=> r_state == ST_LEAD)
        else $error("sequencer did not return to lead after last element");

    a_gap_then_sym: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        go && r_state == ST_GAP |=> r_state == ST_SYM && r_sym == $past(r_sym) + SYM_W'(1))
        else $error("element gap not followed by next symbol");

    a_mid_char_head_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_LEAD |-> i_q_valid)
        else $error("queue head lost in the middle of a character");

    a_sym_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SYM |-> LEN_W'(r_sym) < d_len)
        else $error("symbol index beyond code length");
`endif

endmodule

/* design/morse_character_keyer_top.sv */
// Top level of the Morse character keyer: front end, queue and element sequencer.
// Each accepted ASCII character becomes a run of timed keying elements on the
// master stream: a space gives one word-gap silence; any other character gives a
// letter-gap silence, then for A-Z, 0-9 and newline (sent as AR) a dot or dash tone
// per symbol with an element-gap silence between symbols. Unmapped characters,
// lower case included, give only the letter gap. tlast marks a character's final
// element. The sequencer emits one element per cycle unless the queue is empty or the
// output is stalled; a coded character gives 2*len elements (lead gap, len tones,
// len-1 element gaps; up to 10 for a five-symbol code), a space or unmapped code one.
// A registered front stage and a two-entry descriptor queue keep taking characters while
// the output is busy or stalled. Timing registers are written through the plain write
// port; the user must do so only while the block is idle, as the block does not enforce it.
module morse_character_keyer_top #(
    parameter int MAX_SYMBOLS = mck_pkg::MAX_SYMBOLS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [6:0] char_code, [7] zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,    // [0] tone_on, [16:1] duration, [23:17] zero pad
    output logic        m_axis_tlast,    // last_element
    input  logic        i_cfg_we,
    input  logic [mck_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [mck_pkg::DUR_W-1:0]     i_cfg_data
);
    localparam int LEN_W  = $clog2(MAX_SYMBOLS + 1);
    localparam int DESC_W = 1 + LEN_W + MAX_SYMBOLS;

    logic                         f_push;
    logic [DESC_W-1:0]            f_desc;
    logic                         q_ready;
    logic                         q_valid;
    logic                         q_pop;
    logic [DESC_W-1:0]            q_desc;
    logic                         b_tone;
    logic [mck_pkg::DUR_W-1:0]    b_dur;
    mck_pkg::t_cfg_wr             cfg_wr;

    assign cfg_wr = '{we: i_cfg_we, idx: i_cfg_idx, data: i_cfg_data};

    mck_front #(
        .MAX_SYMBOLS(MAX_SYMBOLS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_char    (s_axis_tdata[6:0]),
        .o_push    (f_push),
        .i_q_ready (q_ready),
        .o_desc    (f_desc)
    );

    mck_queue #(
        .WIDTH(DESC_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .o_ready (q_ready),
        .i_data  (f_desc),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_desc)
    );

    mck_back #(
        .MAX_SYMBOLS(MAX_SYMBOLS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg_wr),
        .i_q_valid (q_valid),
        .o_q_pop   (q_pop),
        .i_q_desc  (q_desc),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_tone    (b_tone),
        .o_dur     (b_dur),
        .o_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {7'd0, b_dur, b_tone};

endmodule

/* tb/morse_character_keyer_top_test.sv */
// Self-checking stream testbench for the Morse character keyer: random and directed characters.
module morse_character_keyer_top_test;
    import mck_pkg::*;

    typedef struct packed {
        logic             tone_on;
        logic [DUR_W-1:0] duration;
        logic             last_element;
    } t_keyed_elem;

    localparam int SEND_GAP_MAX   = 7;
    localparam int RECV_STALL_MAX = 7;
    localparam int REPORT_LIMIT   = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP = '1;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata  = '0;    // [6:0] char_code, [7] zero pad
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [23:0]          m_axis_tdata;          // [0] tone_on, [16:1] duration, [23:17] pad
    logic                 m_axis_tlast;          // last_element
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx     = '0;
    logic [DUR_W-1:0]     i_cfg_data    = '0;

    // timing registers as the block should hold them
    logic [DUR_W-1:0] dot_ms        = RST_DOT_TIME;
    logic [DUR_W-1:0] dash_ms       = RST_DASH_TIME;
    logic [DUR_W-1:0] elem_gap_ms   = RST_ELEMENT_GAP;
    logic [DUR_W-1:0] letter_gap_ms = RST_LETTER_GAP;
    logic [DUR_W-1:0] word_gap_ms   = RST_WORD_GAP;

    logic [CHAR_W-1:0] char_backlog[$];
    t_keyed_elem       expected_elems[$];
    string             mapped_chars = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789\n";

    int mismatches   = 0;
    int send_gap     = 0;
    int recv_stall   = 0;
    bit gap_drawn    = 1'b0;
    bit char_fire    = 1'b0;
    bit sink_blocked = 1'b0;
    bit no_idle      = 1'b0;

    morse_character_keyer_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // dots and dashes per character, "" when the character has no code
    function automatic string morse_pattern(input logic [CHAR_W-1:0] c);
        case ({1'b0, c})
            "A": return ".-";     "B": return "-...";   "C": return "-.-.";
            "D": return "-..";    "E": return ".";      "F": return "..-.";
            "G": return "--.";    "H": return "....";   "I": return "..";
            "J": return ".---";   "K": return "-.-";    "L": return ".-..";
            "M": return "--";     "N": return "-.";     "O": return "---";
            "P": return ".--.";   "Q": return "--.-";   "R": return ".-.";
            "S": return "...";    "T": return "-";      "U": return "..-";
            "V": return "...-";   "W": return ".--";    "X": return "-..-";
            "Y": return "-.--";   "Z": return "--..";
            "0": return "-----";  "1": return ".----";  "2": return "..---";
            "3": return "...--";  "4": return "....-";  "5": return ".....";
            "6": return "-....";  "7": return "--...";  "8": return "---..";
            "9": return "----.";
            {1'b0, CHAR_NEWLINE}: return ".-.-.";
            default: return "";
        endcase
    endfunction

    task automatic predict_keying(input logic [CHAR_W-1:0] c);
        string code;
        int    n;
        if (c == CHAR_SPACE) begin
            expected_elems.push_back('{1'b0, word_gap_ms, 1'b1});
        end else begin
            code = morse_pattern(c);
            n = code.len();
            if (n > MAX_SYMBOLS) n = MAX_SYMBOLS;
            expected_elems.push_back('{1'b0, letter_gap_ms, n == 0});
            for (int i = 0; i < n; i++) begin
                expected_elems.push_back('{1'b1, (code[i] == "-") ? dash_ms : dot_ms,
                                          i == n - 1});
                if (i < n - 1) expected_elems.push_back('{1'b0, elem_gap_ms, 1'b0});
            end
        end
    endtask

    task automatic flag_mismatch(input string what, input t_keyed_elem want,
                                 input t_keyed_elem got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%s: expected tone %0b dur %0d last %0b, got tone %0b dur %0d last %0b",
                     what, want.tone_on, want.duration, want.last_element,
                     got.tone_on, got.duration, got.last_element);
    endtask

    // sample both handshakes; predict before checking so a same-edge result still lines up
    always @(posedge i_clk) begin : keying_monitor
        t_keyed_elem got;
        t_keyed_elem want;
        char_fire = i_rst_n && s_axis_tvalid && s_axis_tready;
        if (char_fire) predict_keying(s_axis_tdata[CHAR_W-1:0]);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{m_axis_tdata[0], m_axis_tdata[DUR_W:1], m_axis_tlast};
            recv_stall = no_idle ? 0 : $urandom_range(0, RECV_STALL_MAX);
            if (expected_elems.size() == 0) begin
                flag_mismatch("unexpected element", '0, got);
            end else begin
                want = expected_elems.pop_front();
                if (got !== want) flag_mismatch("element mismatch", want, got);
            end
        end
    end

    always @(negedge i_clk) begin : char_driver
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!(s_axis_tvalid && !char_fire)) begin
            if (!gap_drawn && char_backlog.size() > 0) begin
                send_gap  = no_idle ? 0 : $urandom_range(0, SEND_GAP_MAX);
                gap_drawn = 1'b1;
            end
            if (gap_drawn && send_gap == 0) begin
                s_axis_tdata  <= {1'b0, char_backlog.pop_front()};
                s_axis_tvalid <= 1'b1;
                gap_drawn     = 1'b0;
            end else begin
                s_axis_tvalid <= 1'b0;
                if (gap_drawn) send_gap--;
            end
        end
    end

    always @(negedge i_clk) begin : sink_driver
        if (!i_rst_n || sink_blocked) begin
            m_axis_tready <= 1'b0;
        end else if (recv_stall > 0) begin
            m_axis_tready <= 1'b0;
            recv_stall--;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic write_timing(input logic [CFG_IDX_W-1:0] idx, input logic [DUR_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        case (idx)
            CFG_DOT_TIME:    dot_ms        = val;
            CFG_DASH_TIME:   dash_ms       = val;
            CFG_ELEMENT_GAP: elem_gap_ms   = val;
            CFG_LETTER_GAP:  letter_gap_ms = val;
            CFG_WORD_GAP:    word_gap_ms   = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic write_all_timing(input logic [DUR_W-1:0] dot, input logic [DUR_W-1:0] dash,
                                    input logic [DUR_W-1:0] eg, input logic [DUR_W-1:0] lg,
                                    input logic [DUR_W-1:0] wg);
        write_timing(CFG_DOT_TIME, dot);
        write_timing(CFG_DASH_TIME, dash);
        write_timing(CFG_ELEMENT_GAP, eg);
        write_timing(CFG_LETTER_GAP, lg);
        write_timing(CFG_WORD_GAP, wg);
    endtask

    // checked at the rising edge, where the sender's state is settled
    task automatic wait_idle();
        while (!(char_backlog.size() == 0 && !gap_drawn && !s_axis_tvalid
                 && expected_elems.size() == 0))
            @(posedge i_clk);
    endtask

    // mostly coded characters, some spaces, the rest anything in range
    function automatic logic [CHAR_W-1:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return CHAR_W'(mapped_chars[$urandom_range(0, mapped_chars.len() - 1)]);
        if (r < 80) return CHAR_SPACE;
        return CHAR_W'($urandom_range(0, (1 << CHAR_W) - 1));
    endfunction

    task automatic queue_random(input int count);
        repeat (count) char_backlog.push_back(pick_char());
    endtask

    initial begin
        #600000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin : sequence_main
        logic [7:0] directed[$];
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset timing: extremes of the code, every code length, unmapped and space
        directed = '{" ", "A", "E", "T", "0", "5", {1'b0, CHAR_NEWLINE}, "1", "9", "Z", "Q",
                     "J", "a", "z", 8'h00, 8'h7F, "~", "@", "[", "/", " ", "H", "M", "O"};
        foreach (directed[i]) char_backlog.push_back(directed[i][CHAR_W-1:0]);
        wait_idle();

        // distinct values, then unused indexes must leave them alone
        write_all_timing(DUR_W'($urandom_range(1, 999)), DUR_W'($urandom_range(1000, 1999)),
                         DUR_W'($urandom_range(2000, 2999)), DUR_W'($urandom_range(3000, 3999)),
                         DUR_W'($urandom_range(4000, 4999)));
        for (int idx = CFG_WORD_GAP + 1; idx <= CFG_IDX_TOP; idx++)
            write_timing(CFG_IDX_W'(idx), DUR_W'($urandom_range(0, 16'hFFFF)));
        char_backlog.push_back("0");
        char_backlog.push_back(" ");
        queue_random(40);
        // long receiver hold-off while the sender keeps offering items
        @(posedge i_clk);
        sink_blocked = 1'b1;
        repeat (120) @(posedge i_clk);
        sink_blocked = 1'b0;
        queue_random(60);
        wait_idle();

        write_all_timing('0, '0, '0, '0, '0);
        queue_random(50);
        wait_idle();
        queue_random(50);
        wait_idle();

        write_all_timing('1, '1, '1, '1, '1);
        @(posedge i_clk);
        no_idle = 1'b1;
        queue_random(50);
        wait_idle();
        @(posedge i_clk);
        no_idle = 1'b0;
        queue_random(50);
        wait_idle();

        write_all_timing(DUR_W'($urandom_range(0, 16'hFFFF)), DUR_W'($urandom_range(0, 16'hFFFF)),
                         DUR_W'($urandom_range(0, 16'hFFFF)), DUR_W'($urandom_range(0, 16'hFFFF)),
                         DUR_W'($urandom_range(0, 16'hFFFF)));
        queue_random(120);
        wait_idle();

        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && expected_elems.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
